// ===== design/x86mov_pkg.sv =====
// Shared types, opcode patterns and helpers for the 8086 MOV decoder.
// No dependencies.
package x86mov_pkg;

	typedef enum logic [2:0] {
		FORM_RM_REG  = 3'd0,
		FORM_IMM_RM  = 3'd1,
		FORM_IMM_REG = 3'd2,
		FORM_MEM_ACC = 3'd3,
		FORM_NONE    = 3'd4
	} form_t;

	localparam logic [7:0] OP_RM_REG   = 8'b10001000;
	localparam logic [7:0] OP_IMM_RM   = 8'b11000110;
	localparam logic [7:0] OP_IMM_REG  = 8'b10110000;
	localparam logic [7:0] OP_MEM_ACC  = 8'b10100000;
	localparam logic [7:0] MASK_RM_REG = 8'hFC;
	localparam logic [7:0] MASK_IMM_RM = 8'hFE;
	localparam logic [7:0] MASK_IMM_RG = 8'hF0;
	localparam logic [7:0] MASK_MEM_AC = 8'hFC;

	localparam logic [1:0] MOD_MEM    = 2'd0;
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP16 = 2'd2;
	localparam logic [2:0] RM_DIRECT  = 3'd6;

	function automatic form_t form_of(input logic [7:0] op);
		form_t f;
		if ((op & MASK_RM_REG) == OP_RM_REG) f = FORM_RM_REG;
		else if ((op & MASK_IMM_RM) == OP_IMM_RM) f = FORM_IMM_RM;
		else if ((op & MASK_IMM_RG) == OP_IMM_REG) f = FORM_IMM_REG;
		else if ((op & MASK_MEM_AC) == OP_MEM_ACC) f = FORM_MEM_ACC;
		else f = FORM_NONE;
		return f;
	endfunction

	function automatic logic wide_of(input logic [7:0] op);
		logic w;
		if (form_of(op) == FORM_IMM_REG) w = op[3];
		else w = op[0];
		return w;
	endfunction

	// displacement byte count implied by a ModRM byte: 0, 1 or 2
	function automatic logic [1:0] disp_len(input logic [7:0] modrm);
		logic [1:0] n;
		case (modrm[7:6])
			MOD_MEM:    n = (modrm[2:0] == RM_DIRECT) ? 2'd2 : 2'd0;
			MOD_DISP8:  n = 2'd1;
			MOD_DISP16: n = 2'd2;
			default:    n = 2'd0;
		endcase
		return n;
	endfunction

endpackage

// ===== design/x86_16_mov_decoder.sv =====
// 8086 MOV decoder: byte-serial phase machine with input and result registers.
// Depends on x86mov_pkg.
// Throughput: one code byte per cycle, sustained while the result side does not stall.
// Path of a result: its last accepted byte goes to the input register, then through the phase
// logic into the result register; a stall on the result side can hold it in the input register.
// Reset: asynchronous, active low; clears phase, held instruction bytes, byte count and both valid flags.
module x86_16_mov_decoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         code_byte,
	output logic               out_valid,
	input  logic               out_stall,
	output logic               status,
	output logic [1:0]         form,
	output logic               to_register,
	output logic               wide,
	output logic [1:0]         mode_field,
	output logic [2:0]         reg_field,
	output logic [2:0]         rm_field,
	output logic signed [15:0] displacement,
	output logic [15:0]        immediate,
	output logic [2:0]         length
);
	import x86mov_pkg::*;

	typedef enum logic [2:0] {
		PH_OPCODE  = 3'd0,
		PH_MODRM   = 3'd1,
		PH_DISP_LO = 3'd2,
		PH_DISP_HI = 3'd3,
		PH_DATA_LO = 3'd4,
		PH_DATA_HI = 3'd5
	} phase_t;

	logic       vld_s1;
	logic [7:0] byte_s1;

	phase_t      phase_q, phase_d;
	logic [7:0]  opcode_q, opcode_d;
	logic [7:0]  modrm_q, modrm_d;
	logic [15:0] disp_q, disp_d;
	logic [15:0] data_q, data_d;
	logic [2:0]  count_q, count_d;

	logic  can_adv, process, accept, done, bad_op;
	form_t held_form, out_form;

	assign can_adv  = !out_valid || !out_stall;
	assign process  = vld_s1 && can_adv;
	assign in_stall = vld_s1 && !can_adv;
	assign accept   = in_valid && !in_stall;

	assign held_form = form_of(opcode_q);

	always_comb begin
		phase_d  = phase_q;
		opcode_d = opcode_q;
		modrm_d  = modrm_q;
		disp_d   = disp_q;
		data_d   = data_q;
		count_d  = count_q + 3'd1;
		done     = 1'b0;
		bad_op   = 1'b0;
		case (phase_q)
			PH_MODRM: begin
				modrm_d = byte_s1;
				if (disp_len(byte_s1) != 2'd0) phase_d = PH_DISP_LO;
				else if (held_form == FORM_IMM_RM || held_form == FORM_IMM_REG)
					phase_d = PH_DATA_LO;
				else done = 1'b1;
			end
			PH_DISP_LO: begin
				if (held_form == FORM_MEM_ACC || disp_len(modrm_q) == 2'd2) begin
					disp_d  = {8'h00, byte_s1};
					phase_d = PH_DISP_HI;
				end else begin
					disp_d = {{8{byte_s1[7]}}, byte_s1};
					if (held_form == FORM_IMM_RM || held_form == FORM_IMM_REG)
						phase_d = PH_DATA_LO;
					else done = 1'b1;
				end
			end
			PH_DISP_HI: begin
				disp_d = {byte_s1, disp_q[7:0]};
				if (held_form == FORM_IMM_RM || held_form == FORM_IMM_REG)
					phase_d = PH_DATA_LO;
				else done = 1'b1;
			end
			PH_DATA_LO: begin
				data_d = {8'h00, byte_s1};
				if (wide_of(opcode_q)) phase_d = PH_DATA_HI;
				else done = 1'b1;
			end
			PH_DATA_HI: begin
				data_d = {byte_s1, data_q[7:0]};
				done   = 1'b1;
			end
			default: begin
				// opcode byte
				opcode_d = byte_s1;
				modrm_d  = '0;
				disp_d   = '0;
				data_d   = '0;
				count_d  = 3'd1;
				case (form_of(byte_s1))
					FORM_NONE:    bad_op  = 1'b1;
					FORM_IMM_REG: phase_d = PH_DATA_LO;
					FORM_MEM_ACC: phase_d = PH_DISP_LO;
					default:      phase_d = PH_MODRM;
				endcase
			end
		endcase
		if (done || bad_op) phase_d = PH_OPCODE;
	end

	assign out_form = form_of(opcode_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			phase_q   <= PH_OPCODE;
			opcode_q  <= '0;
			modrm_q   <= '0;
			disp_q    <= '0;
			data_q    <= '0;
			count_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (accept) begin
				vld_s1  <= 1'b1;
				byte_s1 <= code_byte;
			end else if (process) begin
				vld_s1 <= 1'b0;
			end

			if (process) begin
				phase_q  <= phase_d;
				opcode_q <= opcode_d;
				modrm_q  <= modrm_d;
				disp_q   <= disp_d;
				data_q   <= data_d;
				count_q  <= count_d;
			end

			if (process && (done || bad_op)) begin
				out_valid    <= 1'b1;
				status       <= bad_op;
				length       <= count_d;
				form         <= '0;
				to_register  <= 1'b0;
				wide         <= 1'b0;
				mode_field   <= '0;
				reg_field    <= '0;
				rm_field     <= '0;
				displacement <= disp_d;
				immediate    <= data_d;
				if (!bad_op) begin
					form <= out_form[1:0];
					wide <= wide_of(opcode_d);
					case (out_form)
						FORM_RM_REG: begin
							to_register <= opcode_d[1];
							mode_field  <= modrm_d[7:6];
							reg_field   <= modrm_d[5:3];
							rm_field    <= modrm_d[2:0];
						end
						FORM_IMM_RM: begin
							mode_field <= modrm_d[7:6];
							reg_field  <= modrm_d[5:3];
							rm_field   <= modrm_d[2:0];
						end
						FORM_IMM_REG: begin
							to_register <= 1'b1;
							reg_field   <= opcode_d[2:0];
						end
						FORM_MEM_ACC: to_register <= ~opcode_d[1];
						default:      to_register <= 1'b0;
					endcase
				end
			end else if (!out_stall) begin
				out_valid <= 1'b0;
			end
		end
	end

	// a new result beat only ever comes from a byte held in the input register
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(vld_s1))
		else $error("result beat without a processed byte");

	a_bad_op_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status |-> length == 3'd1 && form == 2'd0 && immediate == 16'd0)
		else $error("unsupported opcode beat not clean");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> vld_s1 && out_valid && out_stall)
		else $error("input stalled without a blocked result");

	a_resync: assert property (@(posedge clk) disable iff (!arst_n)
		process && (done || bad_op) |=> phase_q == PH_OPCODE && out_valid)
		else $error("no return to opcode phase after a result");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_OPCODE |-> count_q >= 3'd1 && count_q <= 3'd5)
		else $error("byte count out of range mid-instruction");

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for x86_16_mov_decoder: byte stream in, decoded MOV beats out, checked
// against an in-bench decoder model. Depends on x86mov_pkg and the decoder RTL.
module tb_top;
	import x86mov_pkg::*;

	localparam int CODE_BYTES  = 830;
	localparam int HOLD_AT     = 420;
	localparam int CALM_LO     = 300;
	localparam int CALM_HI     = 650;
	localparam int CYCLE_LIMIT = 100000;
	localparam int IDLE_PCT    = 22;

	typedef enum logic [2:0] {
		ST_OPCODE, ST_MODRM, ST_DISP_LO, ST_DISP_HI, ST_DATA_LO, ST_DATA_HI
	} dec_state_t;

	typedef struct {
		logic              status;
		logic [1:0]        form;
		logic              to_reg;
		logic              wide;
		logic [1:0]        mode;
		logic [2:0]        reg_no;
		logic [2:0]        rm;
		logic signed [15:0] disp;
		logic [15:0]       imm;
		logic [2:0]        len;
	} mov_beat_t;

	typedef struct {
		logic [7:0] b;
		bit         hold;
	} code_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] code_byte = 8'h00;
	logic out_valid;
	logic out_stall = 1'b0;
	logic status;
	logic [1:0] form;
	logic to_register;
	logic wide;
	logic [1:0] mode_field;
	logic [2:0] reg_field;
	logic [2:0] rm_field;
	logic signed [15:0] displacement;
	logic [15:0] immediate;
	logic [2:0] length;

	code_item_t code_stream[$];
	mov_beat_t  beats_due[$];
	bit         hold_next = 1'b0;
	bit         drained = 1'b1;
	int         errors = 0;
	int         cyc = 0;

	// decoder model state
	dec_state_t st = ST_OPCODE;
	logic [7:0]  op_q = '0;
	logic [7:0]  modrm_q = '0;
	logic [15:0] disp_q = '0;
	logic [15:0] data_q = '0;
	logic [2:0]  cnt_q = '0;

	x86_16_mov_decoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.code_byte(code_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.form(form),
		.to_register(to_register),
		.wide(wide),
		.mode_field(mode_field),
		.reg_field(reg_field),
		.rm_field(rm_field),
		.displacement(displacement),
		.immediate(immediate),
		.length(length)
	);

	always #5 clk = ~clk;

	function automatic form_t classify(input logic [7:0] op);
		if ((op & MASK_RM_REG) == OP_RM_REG) return FORM_RM_REG;
		if ((op & MASK_IMM_RM) == OP_IMM_RM) return FORM_IMM_RM;
		if ((op & MASK_IMM_RG) == OP_IMM_REG) return FORM_IMM_REG;
		if ((op & MASK_MEM_AC) == OP_MEM_ACC) return FORM_MEM_ACC;
		return FORM_NONE;
	endfunction

	function automatic bit op_wide(input logic [7:0] op);
		return (classify(op) == FORM_IMM_REG) ? op[3] : op[0];
	endfunction

	function automatic int disp_bytes(input logic [7:0] modrm);
		if (modrm[7:6] == MOD_MEM) return (modrm[2:0] == RM_DIRECT) ? 2 : 0;
		if (modrm[7:6] == MOD_DISP8) return 1;
		if (modrm[7:6] == MOD_DISP16) return 2;
		return 0;
	endfunction

	// displacement finished: immediate forms go on to data, others complete
	function automatic bit disp_done(input form_t f);
		if (f == FORM_IMM_RM || f == FORM_IMM_REG) begin
			st = ST_DATA_LO;
			return 1'b0;
		end
		return 1'b1;
	endfunction

	// advance the model by one code byte; returns 1 when a beat is due
	function automatic bit decode_step(input logic [7:0] b, output mov_beat_t r);
		form_t f;
		bit done;
		r = '{default: '0};
		done = 1'b0;
		if (st == ST_OPCODE) begin
			op_q = b;
			modrm_q = '0;
			disp_q = '0;
			data_q = '0;
			cnt_q = 3'd1;
			f = classify(b);
			case (f)
				FORM_NONE: begin
					r.status = 1'b1;
					r.len = 3'd1;
					return 1'b1;
				end
				FORM_IMM_REG: st = ST_DATA_LO;
				FORM_MEM_ACC: st = ST_DISP_LO;
				default: st = ST_MODRM;
			endcase
			return 1'b0;
		end
		cnt_q = cnt_q + 3'd1;
		f = classify(op_q);
		case (st)
			ST_MODRM: begin
				modrm_q = b;
				if (disp_bytes(b) != 0) st = ST_DISP_LO;
				else done = disp_done(f);
			end
			ST_DISP_LO: begin
				disp_q = {8'h00, b};
				if (f == FORM_MEM_ACC || disp_bytes(modrm_q) == 2) begin
					st = ST_DISP_HI;
				end else begin
					disp_q = {{8{b[7]}}, b};
					done = disp_done(f);
				end
			end
			ST_DISP_HI: begin
				disp_q[15:8] = b;
				done = disp_done(f);
			end
			ST_DATA_LO: begin
				data_q = {8'h00, b};
				if (op_wide(op_q)) st = ST_DATA_HI;
				else done = 1'b1;
			end
			default: begin
				data_q[15:8] = b;
				done = 1'b1;
			end
		endcase
		if (done) begin
			st = ST_OPCODE;
			r.form = f[1:0];
			r.wide = op_wide(op_q);
			r.disp = disp_q;
			r.imm = data_q;
			r.len = cnt_q;
			if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
				r.mode = modrm_q[7:6];
				r.reg_no = modrm_q[5:3];
				r.rm = modrm_q[2:0];
			end
			case (f)
				FORM_RM_REG: r.to_reg = op_q[1];
				FORM_IMM_REG: begin
					r.to_reg = 1'b1;
					r.reg_no = op_q[2:0];
				end
				FORM_MEM_ACC: r.to_reg = ~op_q[1];
				default: r.to_reg = 1'b0;
			endcase
		end
		return done;
	endfunction

	task automatic push_code(input logic [7:0] b);
		code_stream.push_back('{b: b, hold: hold_next});
		hold_next = 1'b0;
	endtask

	// one instruction: opcode plus whatever bytes its form and ModRM call for
	task automatic put_insn(input logic [7:0] op, input logic [7:0] modrm,
			input logic [15:0] disp, input logic [15:0] imm);
		form_t f;
		int nd;
		f = classify(op);
		nd = 0;
		push_code(op);
		if (f == FORM_RM_REG || f == FORM_IMM_RM) begin
			push_code(modrm);
			nd = disp_bytes(modrm);
		end else if (f == FORM_MEM_ACC) begin
			nd = 2;
		end
		if (nd > 0) push_code(disp[7:0]);
		if (nd == 2) push_code(disp[15:8]);
		if (f == FORM_IMM_RM || f == FORM_IMM_REG) begin
			push_code(imm[7:0]);
			if (op_wide(op)) push_code(imm[15:8]);
		end
	endtask

	task automatic put_random_mov(input form_t f);
		logic [7:0] op;
		logic [7:0] modrm;
		modrm = $urandom;
		// direct addressing is rare in plain random ModRM bytes
		if ($urandom_range(3) == 0) modrm = {MOD_MEM, modrm[5:3], RM_DIRECT};
		case (f)
			FORM_RM_REG: op = OP_RM_REG | 8'($urandom_range(3));
			FORM_IMM_RM: op = OP_IMM_RM | 8'($urandom_range(1));
			FORM_IMM_REG: op = OP_IMM_REG | 8'($urandom_range(15));
			default: op = OP_MEM_ACC | 8'($urandom_range(3));
		endcase
		put_insn(op, modrm, 16'($urandom), 16'($urandom));
	endtask

	task automatic check_beat(input mov_beat_t e);
		if (status !== e.status) begin
			errors++;
			$error("status: expected %0d, got %0d", e.status, status);
		end
		if (form !== e.form) begin
			errors++;
			$error("form: expected %0d, got %0d", e.form, form);
		end
		if (to_register !== e.to_reg) begin
			errors++;
			$error("to_register: expected %0d, got %0d", e.to_reg, to_register);
		end
		if (wide !== e.wide) begin
			errors++;
			$error("wide: expected %0d, got %0d", e.wide, wide);
		end
		if (mode_field !== e.mode) begin
			errors++;
			$error("mode_field: expected %0d, got %0d", e.mode, mode_field);
		end
		if (reg_field !== e.reg_no) begin
			errors++;
			$error("reg_field: expected %0d, got %0d", e.reg_no, reg_field);
		end
		if (rm_field !== e.rm) begin
			errors++;
			$error("rm_field: expected %0d, got %0d", e.rm, rm_field);
		end
		if (displacement !== e.disp) begin
			errors++;
			$error("displacement: expected %0d, got %0d", e.disp, displacement);
		end
		if (immediate !== e.imm) begin
			errors++;
			$error("immediate: expected 0x%04h, got 0x%04h", e.imm, immediate);
		end
		if (length !== e.len) begin
			errors++;
			$error("length: expected %0d, got %0d", e.len, length);
		end
	endtask

	// driver: a held-flag byte waits until nothing is in flight and all beats are out
	always @(posedge clk or negedge arst_n) begin
		bit idle;
		if (!arst_n) begin
			in_valid <= 1'b0;
			code_byte <= 8'h00;
		end else if (!in_valid || !in_stall) begin
			idle = (cyc < CALM_LO || cyc >= CALM_HI) && $urandom_range(99) < IDLE_PCT;
			if (code_stream.size() != 0 && !idle &&
					!(code_stream[0].hold && (in_valid || !drained))) begin
				in_valid <= 1'b1;
				code_byte <= code_stream[0].b;
				void'(code_stream.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: check the outgoing beat first, then model the accepted byte
	always @(posedge clk or negedge arst_n) begin
		mov_beat_t nb;
		if (!arst_n) begin
			out_stall <= 1'b0;
			drained <= 1'b1;
		end else begin
			if (out_valid && !out_stall) begin
				if (beats_due.size() == 0) begin
					errors++;
					$error("result beat with nothing expected");
				end else begin
					check_beat(beats_due.pop_front());
				end
			end
			if (in_valid && !in_stall) begin
				if (decode_step(code_byte, nb)) beats_due.push_back(nb);
			end
			out_stall <= (cyc < CALM_LO || cyc >= CALM_HI) && $urandom_range(99) < IDLE_PCT;
			drained <= (beats_due.size() == 0);
		end
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc == CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		bit held;
		held = 1'b0;

		// directed: bad opcodes, each form, each displacement size, widths
		push_code(8'h00);
		push_code(8'hFF);
		put_insn(OP_RM_REG | 8'h03, {MOD_MEM, 3'd0, RM_DIRECT}, 16'h8000, 16'h0000);
		put_insn(OP_RM_REG, {MOD_MEM, 3'd0, 3'd0}, 16'h0000, 16'h0000);
		put_insn(OP_RM_REG, {MOD_DISP8, 3'd0, 3'd5}, 16'h00FF, 16'h0000);
		put_insn(OP_RM_REG | 8'h02, {2'b11, 3'd0, 3'd1}, 16'h0000, 16'h0000);
		put_insn(OP_IMM_RM | 8'h01, {MOD_DISP16, 3'd7, 3'd7}, 16'h7FFF, 16'hFFFF);
		put_insn(OP_IMM_RM, {2'b11, 3'd7, 3'd0}, 16'h0000, 16'h0080);
		put_insn(OP_IMM_REG, 8'h00, 16'h0000, 16'h0000);
		put_insn(OP_IMM_REG | 8'h0F, 8'h00, 16'h0000, 16'hFFFF);
		put_insn(OP_MEM_ACC, 8'h00, 16'h0000, 16'h0000);
		put_insn(OP_MEM_ACC | 8'h03, 8'h00, 16'hFFFF, 16'h0000);

		// random: mostly whole instructions, some stray bytes that break the framing
		while (code_stream.size() < CODE_BYTES) begin
			if (!held && code_stream.size() >= HOLD_AT) begin
				hold_next = 1'b1;
				held = 1'b1;
			end
			if ($urandom_range(9) == 0) push_code(8'($urandom));
			else put_random_mov(form_t'($urandom_range(3)));
		end

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		while (code_stream.size() != 0 || in_valid) @(posedge clk);
		while (beats_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		if (errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end

endmodule
